// ===== rtl/nmea_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_pkg : shared types and constants of the NMEA RMC/GGA field parser
// Field identifiers, the job handed from the front end to the back end
// through the job queue, and the power-of-ten table for fixed-point scaling.
// ----------------------------------------------------------------------------
package nmea_pkg;

	localparam int FRACTION_DIGITS_DEF = 5;
	localparam int QUEUE_DEPTH_DEF = 4;

	// largest magnitude a numeric field may reach
	localparam logic [30:0] MAG_MAX = '1;

	// result identifiers
	localparam logic [3:0] FID_HOUR   = 4'd0;
	localparam logic [3:0] FID_FIX    = 4'd3;
	localparam logic [3:0] FID_LAT    = 4'd4;
	localparam logic [3:0] FID_LON    = 4'd6;
	localparam logic [3:0] FID_SPEED  = 4'd8;
	localparam logic [3:0] FID_COURSE = 4'd9;
	localparam logic [3:0] FID_DAY    = 4'd10;
	localparam logic [3:0] FID_SATS   = 4'd13;
	localparam logic [3:0] FID_ALT    = 4'd14;
	localparam logic [3:0] FID_END    = 4'd15;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_TIME,
		CLS_DATE,
		CLS_FLAG,
		CLS_FIXED,
		CLS_INT
	} field_class_t;

	// OP_NUM: one numeric result; OP_TRIPLE: three two-digit results
	typedef enum logic [1:0] {
		OP_NONE,
		OP_NUM,
		OP_TRIPLE
	} job_op_t;

	typedef struct packed {
		logic        kind;
		job_op_t     op;
		logic [3:0]  id;
		logic [23:0] digits;
		logic [30:0] mag;
		logic        minus;
		logic [2:0]  scale;
		logic        eos;
	} job_t;

	function automatic logic [23:0] pow10(input logic [2:0] k);
		logic [23:0] p;
		case (k)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			3'd7: p = 24'd10000000;
			default: p = 24'd1;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/nmea_rmc_gga_field_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_gga_field_parser : NMEA 0183 RMC/GGA sentence field parser
// Takes a receiver's character stream and returns decoded time, fix, position,
// speed, course, date, satellite count and altitude fields plus end markers.
//
// Input channel (in_valid / in_stall / rx_byte): one ASCII character per
// beat, taken in every cycle while the job queue has room; in_stall rises
// only when the queue is full.
// Output channel (out_valid / out_stall / result fields): one result per
// beat. A field closed by ',' or '*' gives zero to three results, and '*'
// adds an end marker (field_id 15, end_of_sentence 1), so one byte may give
// up to four results, presented one per cycle while out_stall is low.
// The first result of a closing byte passes through the job queue and then
// the output register before it is offered.
// Sustained rate is one byte per cycle; it drops only when bytes produce
// results faster than one per cycle or the receiver stalls. When out_stall is
// high the current result holds, the queue fills and then stalls the input.
// Reset (arst_n low) clears header matching, field state, the queue and the
// output valid flag; no sentence is in progress afterwards.
// ----------------------------------------------------------------------------
module nmea_rmc_gga_field_parser #(
	parameter int FRACTION_DIGITS = nmea_pkg::FRACTION_DIGITS_DEF,
	parameter int QUEUE_DEPTH = nmea_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                sentence_kind,
	output logic [3:0]          field_id,
	output logic signed [31:0]  field_value,
	output logic                end_of_sentence
);

	logic           q_full;
	logic           push;
	nmea_pkg::job_t push_job;
	logic           pop;
	logic           head_valid;
	nmea_pkg::job_t head_job;

	// classify bytes and post a job per asterisk and per comma that gives results
	nmea_front #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// decouple byte intake from result delivery
	nmea_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// expand each job into results, one beat at a time
	nmea_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (head_valid),
		.head            (head_job),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sentence_kind   (sentence_kind),
		.field_id        (field_id),
		.field_value     (field_value),
		.end_of_sentence (end_of_sentence)
	);

endmodule

// ===== rtl/nmea_front.sv =====
// ----------------------------------------------------------------------------
// nmea_front : header matcher and per-field character collector
// Tracks the sentence header and comma count, gathers the characters of the
// current field; posts a job at each asterisk and each result-giving comma.
// ----------------------------------------------------------------------------
module nmea_front #(
	parameter int FRACTION_DIGITS = nmea_pkg::FRACTION_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	input  logic             q_full,
	output logic             push,
	output nmea_pkg::job_t   push_job
);

	localparam logic [2:0] FRAC_LIMIT = 3'(FRACTION_DIGITS);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [7:0] CH_W      = 8'h57;

	function automatic logic [7:0] hdr_char(input logic kind, input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = CH_DOLLAR;
			3'd1: ch = CH_G;
			3'd2: ch = CH_P;
			3'd4: ch = kind ? CH_G : CH_M;
			3'd5: ch = kind ? CH_A : CH_C;
			3'd6: ch = CH_COMMA;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic nmea_pkg::field_class_t class_of(input logic kind,
			input logic [3:0] fnum);
		nmea_pkg::field_class_t cls;
		if (!kind) begin
			case (fnum)
				4'd0: cls = nmea_pkg::CLS_TIME;
				4'd1, 4'd3, 4'd5: cls = nmea_pkg::CLS_FLAG;
				4'd2, 4'd4: cls = nmea_pkg::CLS_FIXED;
				4'd6, 4'd7: cls = nmea_pkg::CLS_INT;
				4'd8: cls = nmea_pkg::CLS_DATE;
				default: cls = nmea_pkg::CLS_NONE;
			endcase
		end else if (fnum inside {4'd6, 4'd8}) begin
			cls = nmea_pkg::CLS_INT;
		end else begin
			cls = nmea_pkg::CLS_NONE;
		end
		return cls;
	endfunction

	logic [2:0]  hdr_pos_q, hdr_pos_d;
	logic        kind_q, kind_d;
	logic        in_body_q, in_body_d;
	logic [3:0]  fnum_q, fnum_d;
	logic [3:0]  cif_q, cif_d;
	logic [23:0] digits_q, digits_d;
	logic [30:0] acc_q, acc_d;
	logic [2:0]  frac_q, frac_d;
	logic        point_q, point_d;
	logic        minus_q, minus_d;
	logic        done_q, done_d;

	nmea_pkg::field_class_t cls;
	nmea_pkg::job_t         close_job;
	logic                   accept;
	logic                   is_digit;
	logic [34:0]            ma_sum;
	logic [30:0]            ma_val;
	logic [7:0]             flag_yes, flag_no;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign cls = class_of(kind_q, fnum_q);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

	// accumulator times ten plus the new digit, saturating
	assign ma_sum = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(rx_byte[3:0]);
	assign ma_val = (ma_sum > 35'(nmea_pkg::MAG_MAX)) ? nmea_pkg::MAG_MAX : ma_sum[30:0];

	always_comb begin
		case (fnum_q)
			4'd1: begin
				flag_yes = CH_A;
				flag_no = CH_V;
			end
			4'd3: begin
				flag_yes = CH_S;
				flag_no = CH_N;
			end
			default: begin
				flag_yes = CH_W;
				flag_no = CH_E;
			end
		endcase
	end

	// job describing what the field now closing gives
	always_comb begin
		close_job = '0;
		close_job.kind = kind_q;
		close_job.digits = digits_q;
		close_job.mag = acc_q;
		close_job.minus = minus_q;
		case (cls)
			nmea_pkg::CLS_TIME: begin
				close_job.op = nmea_pkg::OP_TRIPLE;
				close_job.id = nmea_pkg::FID_HOUR;
			end
			nmea_pkg::CLS_DATE: begin
				close_job.op = nmea_pkg::OP_TRIPLE;
				close_job.id = nmea_pkg::FID_DAY;
			end
			nmea_pkg::CLS_FLAG: begin
				close_job.op = (digits_q != '0) ? nmea_pkg::OP_NUM : nmea_pkg::OP_NONE;
				close_job.id = nmea_pkg::FID_FIX + (fnum_q - 4'd1);
				close_job.mag = {30'b0, digits_q[1]};
				close_job.minus = 1'b0;
			end
			nmea_pkg::CLS_FIXED: begin
				close_job.op = nmea_pkg::OP_NUM;
				close_job.id = (fnum_q == 4'd2) ? nmea_pkg::FID_LAT : nmea_pkg::FID_LON;
				close_job.scale = FRAC_LIMIT - frac_q;
			end
			nmea_pkg::CLS_INT: begin
				close_job.op = nmea_pkg::OP_NUM;
				if (!kind_q) begin
					close_job.id = (fnum_q == 4'd6) ? nmea_pkg::FID_SPEED
						: nmea_pkg::FID_COURSE;
				end else begin
					close_job.id = (fnum_q == 4'd6) ? nmea_pkg::FID_SATS
						: nmea_pkg::FID_ALT;
				end
			end
			default: close_job.op = nmea_pkg::OP_NONE;
		endcase
		if (cif_q == 4'd0) begin
			close_job.op = nmea_pkg::OP_NONE;
		end
	end

	always_comb begin
		hdr_pos_d = hdr_pos_q;
		kind_d = kind_q;
		in_body_d = in_body_q;
		fnum_d = fnum_q;
		cif_d = cif_q;
		digits_d = digits_q;
		acc_d = acc_q;
		frac_d = frac_q;
		point_d = point_q;
		minus_d = minus_q;
		done_d = done_q;
		push = 1'b0;
		push_job = close_job;
		push_job.eos = (rx_byte == CH_STAR);

		if (accept) begin
			if (in_body_q) begin
				if (rx_byte == CH_DOLLAR || rx_byte == CH_COMMA || rx_byte == CH_STAR) begin
					cif_d = '0;
					digits_d = '0;
					acc_d = '0;
					frac_d = '0;
					point_d = 1'b0;
					minus_d = 1'b0;
					done_d = 1'b0;
					if (rx_byte == CH_DOLLAR) begin
						// drop the sentence and start a new header
						in_body_d = 1'b0;
						hdr_pos_d = 3'd1;
						fnum_d = '0;
					end else if (rx_byte == CH_COMMA) begin
						push = (close_job.op != nmea_pkg::OP_NONE);
						if (fnum_q != 4'd15) begin
							fnum_d = fnum_q + 4'd1;
						end
					end else begin
						push = 1'b1;
						in_body_d = 1'b0;
						hdr_pos_d = '0;
						fnum_d = '0;
					end
				end else begin
					case (cls)
						nmea_pkg::CLS_TIME, nmea_pkg::CLS_DATE: begin
							if (cif_q < 4'd6 && is_digit) begin
								digits_d[{cif_q[2:0], 2'b00} +: 4] = rx_byte[3:0];
							end
						end
						nmea_pkg::CLS_FLAG: begin
							if (rx_byte == flag_yes) begin
								digits_d = 24'd2;
							end else if (rx_byte == flag_no) begin
								digits_d = 24'd1;
							end
						end
						nmea_pkg::CLS_FIXED, nmea_pkg::CLS_INT: begin
							if (!done_q) begin
								if (cif_q == 4'd0
										&& (rx_byte == CH_MINUS || rx_byte == CH_PLUS)) begin
									minus_d = (rx_byte == CH_MINUS);
								end else if (is_digit) begin
									if (!point_q) begin
										acc_d = ma_val;
									end else if (frac_q < FRAC_LIMIT) begin
										acc_d = ma_val;
										frac_d = frac_q + 3'd1;
									end
								end else if (rx_byte == CH_POINT
										&& cls == nmea_pkg::CLS_FIXED && !point_q) begin
									point_d = 1'b1;
								end else begin
									done_d = 1'b1;
								end
							end
						end
						default: ;
					endcase
					if (cif_q != 4'd15) begin
						cif_d = cif_q + 4'd1;
					end
				end
			end else begin
				if (hdr_pos_q == 3'd3 && (rx_byte == CH_R || rx_byte == CH_G)) begin
					kind_d = (rx_byte == CH_G);
					hdr_pos_d = 3'd4;
				end else if (hdr_pos_q != 3'd3 && rx_byte == hdr_char(kind_q, hdr_pos_q)) begin
					if (hdr_pos_q == 3'd6) begin
						hdr_pos_d = '0;
						in_body_d = 1'b1;
						fnum_d = '0;
						cif_d = '0;
						digits_d = '0;
						acc_d = '0;
						frac_d = '0;
						point_d = 1'b0;
						minus_d = 1'b0;
						done_d = 1'b0;
					end else begin
						hdr_pos_d = hdr_pos_q + 3'd1;
					end
				end else begin
					hdr_pos_d = (rx_byte == CH_DOLLAR) ? 3'd1 : 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q <= '0;
			kind_q <= 1'b0;
			in_body_q <= 1'b0;
			fnum_q <= '0;
			cif_q <= '0;
			digits_q <= '0;
			acc_q <= '0;
			frac_q <= '0;
			point_q <= 1'b0;
			minus_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			hdr_pos_q <= hdr_pos_d;
			kind_q <= kind_d;
			in_body_q <= in_body_d;
			fnum_q <= fnum_d;
			cif_q <= cif_d;
			digits_q <= digits_d;
			acc_q <= acc_d;
			frac_q <= frac_d;
			point_q <= point_d;
			minus_q <= minus_d;
			done_q <= done_d;
		end
	end

	// header matching is idle while a body is being parsed
	assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> hdr_pos_q == 3'd0)
		else $error("header position not cleared inside a body");

endmodule

// ===== rtl/nmea_queue.sv =====
// ----------------------------------------------------------------------------
// nmea_queue : short job queue between front end and back end
// Register-based FIFO with a show-ahead head entry.
// ----------------------------------------------------------------------------
module nmea_queue #(
	parameter int DEPTH = nmea_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nmea_pkg::job_t   push_job,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output nmea_pkg::job_t   head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	nmea_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("job queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("job queue count lost a pop");

endmodule

// ===== rtl/nmea_back.sv =====
// ----------------------------------------------------------------------------
// nmea_back : result generator
// Expands each queued job into results, one per cycle unless stalled, scales
// fixed-point angles and holds results in the output register until taken.
// ----------------------------------------------------------------------------
module nmea_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  nmea_pkg::job_t      head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                sentence_kind,
	output logic [3:0]          field_id,
	output logic signed [31:0]  field_value,
	output logic                end_of_sentence
);

	logic        out_valid_q;
	logic        kind_q;
	logic [3:0]  id_q;
	logic [31:0] value_q;
	logic        eos_q;
	logic [1:0]  sub_q;

	logic [2:0]  res_cnt;
	logic        last;
	logic        emit;
	logic [3:0]  tens, ones;
	logic [6:0]  pair;
	logic [54:0] prod;
	logic [30:0] sat_mag;
	logic [31:0] num_value;
	logic [3:0]  res_id;
	logic [31:0] res_value;
	logic        res_eos;

	always_comb begin
		case (head.op)
			nmea_pkg::OP_TRIPLE: res_cnt = 3'd3;
			nmea_pkg::OP_NUM: res_cnt = 3'd1;
			default: res_cnt = 3'd0;
		endcase
		res_cnt = res_cnt + 3'(head.eos);
	end

	assign last = ({1'b0, sub_q} == res_cnt - 3'd1);
	assign emit = q_valid && (!out_valid_q || !out_stall);
	assign pop = emit && last;

	// two-digit value from digit pair sub_q
	assign tens = head.digits[{sub_q, 3'b000} +: 4];
	assign ones = head.digits[{sub_q, 3'b100} +: 4];
	assign pair = 7'({tens, 3'b000}) + 7'({tens, 1'b0}) + 7'(ones);

	// scale, saturate, then apply sign
	assign prod = 55'(head.mag) * 55'(nmea_pkg::pow10(head.scale));
	assign sat_mag = (prod > 55'(nmea_pkg::MAG_MAX)) ? nmea_pkg::MAG_MAX : prod[30:0];
	assign num_value = head.minus ? 32'd0 - {1'b0, sat_mag} : {1'b0, sat_mag};

	always_comb begin
		if (head.op == nmea_pkg::OP_TRIPLE && sub_q != 2'd3) begin
			res_id = head.id + 4'(sub_q);
			res_value = 32'(pair);
			res_eos = 1'b0;
		end else if (head.op == nmea_pkg::OP_NUM && sub_q == 2'd0) begin
			res_id = head.id;
			res_value = num_value;
			res_eos = 1'b0;
		end else begin
			res_id = nmea_pkg::FID_END;
			res_value = '0;
			res_eos = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				sub_q <= last ? 2'd0 : sub_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= head.kind;
			id_q <= res_id;
			value_q <= res_value;
			eos_q <= res_eos;
		end
	end

	assign out_valid = out_valid_q;
	assign sentence_kind = kind_q;
	assign field_id = id_q;
	assign field_value = value_q;
	assign end_of_sentence = eos_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> {1'b0, sub_q} < res_cnt)
		else $error("result index beyond the job's result count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eos_q) |-> id_q == nmea_pkg::FID_END)
		else $error("end marker carries a field identifier");

endmodule
